// ----- rtl/outlier_rejecting_window_average_core_macros.svh -----
// Assertion macros shared by the outlier-rejecting window average RTL.
// Each macro builds one labeled concurrent assertion, clocked on the rising
// edge and disabled while the asynchronous reset is asserted.
`ifndef OUTLIER_REJECTING_WINDOW_AVERAGE_CORE_MACROS_SVH
`define OUTLIER_REJECTING_WINDOW_AVERAGE_CORE_MACROS_SVH

// Same-cycle implication.
`define ORWA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define ORWA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/orwa_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// orwa_pkg
// Shared types and constants of the outlier-rejecting window average core.
// ----------------------------------------------------------------------------
package orwa_pkg;

	localparam int WINDOW_DEPTH_DEF = 5;
	localparam int SAMPLE_WIDTH_DEF = 16;

	localparam int RATIO_W  = 4;
	localparam int ACTION_W = 2;
	localparam int COUNT_W  = 3;

	localparam logic [RATIO_W-1:0] RATIO_RESET = 4'd3;

	localparam logic [ACTION_W-1:0] ACT_PUSH  = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_FILL  = 2'd2;

	typedef enum logic [6:0] {
		ST_IDLE     = 7'b0000001,
		ST_PREP     = 7'b0000010,
		ST_SCAN     = 7'b0000100,
		ST_FLUSH    = 7'b0001000,
		ST_DIV_INIT = 7'b0010000,
		ST_DIV      = 7'b0100000,
		ST_DONE     = 7'b1000000
	} state_t;

	typedef struct packed {
		logic apply;
		logic prep;
		logic scan;
		logic div_init;
		logic div_step;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} status_t;

endpackage
`default_nettype wire

// ----- rtl/orwa_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// orwa_ctrl
// Sequencer: takes one request, steps the datapath through the window scan
// and the divide, then hands the result to the output register.
// ----------------------------------------------------------------------------
module orwa_ctrl #(
	parameter int WINDOW_DEPTH = orwa_pkg::WINDOW_DEPTH_DEF,
	parameter int SAMPLE_WIDTH = orwa_pkg::SAMPLE_WIDTH_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  wire orwa_pkg::status_t               status,
	output orwa_pkg::cmd_t                       cmd,
	output logic [$clog2(WINDOW_DEPTH)-1:0]      scan_idx
);

	localparam int IDX_W = $clog2(WINDOW_DEPTH);
	localparam int SUM_W = SAMPLE_WIDTH + $clog2(WINDOW_DEPTH);
	localparam int CTR_MAX = (SUM_W > WINDOW_DEPTH) ? SUM_W : WINDOW_DEPTH;
	localparam int CTR_W = $clog2(CTR_MAX + 1);
	localparam logic [CTR_W-1:0] SCAN_LAST = CTR_W'(WINDOW_DEPTH - 1);
	localparam logic [CTR_W-1:0] DIV_LAST  = CTR_W'(SUM_W - 1);

	orwa_pkg::state_t state_q, state_d;
	logic [CTR_W-1:0] cnt_q, cnt_d;

	always_comb begin
		state_d       = state_q;
		cnt_d         = cnt_q;
		cmd           = '0;
		s_axis_tready = 1'b0;
		unique case (state_q)
			orwa_pkg::ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					cmd.apply = 1'b1;
					state_d   = orwa_pkg::ST_PREP;
				end
			end
			orwa_pkg::ST_PREP: begin
				cmd.prep = 1'b1;
				cnt_d    = '0;
				state_d  = orwa_pkg::ST_SCAN;
			end
			orwa_pkg::ST_SCAN: begin
				cmd.scan = 1'b1;
				if (cnt_q == SCAN_LAST) begin
					state_d = orwa_pkg::ST_FLUSH;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			orwa_pkg::ST_FLUSH: begin
				// The last slot leaves the compare stage in this cycle.
				state_d = orwa_pkg::ST_DIV_INIT;
			end
			orwa_pkg::ST_DIV_INIT: begin
				cmd.div_init = 1'b1;
				cnt_d        = '0;
				state_d      = orwa_pkg::ST_DIV;
			end
			orwa_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == DIV_LAST) begin
					state_d = orwa_pkg::ST_DONE;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			orwa_pkg::ST_DONE: begin
				if (status.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = orwa_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = orwa_pkg::ST_IDLE;
			end
		endcase
	end

	assign scan_idx = cnt_q[IDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= orwa_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/orwa_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// orwa_datapath
// Sample window with running sum, two-stage outlier scan, bit-serial divider
// and the output register.
// ----------------------------------------------------------------------------
`include "outlier_rejecting_window_average_core_macros.svh"
module orwa_datapath #(
	parameter int WINDOW_DEPTH = orwa_pkg::WINDOW_DEPTH_DEF,
	parameter int SAMPLE_WIDTH = orwa_pkg::SAMPLE_WIDTH_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire orwa_pkg::cmd_t                      cmd,
	input  wire logic [$clog2(WINDOW_DEPTH)-1:0]     scan_idx,
	output orwa_pkg::status_t                        status,
	input  wire logic [orwa_pkg::ACTION_W-1:0]       action,
	input  wire logic signed [SAMPLE_WIDTH-1:0]      sample,
	input  wire logic                                cfg_we,
	input  wire logic [orwa_pkg::RATIO_W-1:0]        cfg_wdata,
	input  wire logic                                out_ready,
	output logic                                     out_valid,
	output logic signed [SAMPLE_WIDTH-1:0]           out_average,
	output logic [orwa_pkg::COUNT_W-1:0]             out_count
);

	localparam int SW    = SAMPLE_WIDTH;
	localparam int N     = WINDOW_DEPTH;
	localparam int CNT_W = $clog2(N + 1);
	localparam int SUM_W = SW + $clog2(N);
	localparam int D_W   = SUM_W + 1;
	localparam int CMP_W = D_W + 4;
	localparam int OC_W  = (CNT_W > orwa_pkg::COUNT_W) ? CNT_W : orwa_pkg::COUNT_W;
	localparam logic signed [SUM_W-1:0] N_S   = SUM_W'(N);
	localparam logic [CMP_W-1:0]        TEN   = CMP_W'(10);
	localparam logic [CNT_W-1:0]        N_CNT = CNT_W'(N);
	localparam logic [OC_W-1:0]         N_OC  = OC_W'(N);

	// Window state, slot 0 newest.
	logic signed [SW-1:0]    win_q [N];
	logic signed [SUM_W-1:0] sum_q;
	logic [orwa_pkg::RATIO_W-1:0] ratio_q;

	logic signed [SUM_W-1:0] sample_ext;
	logic signed [SUM_W-1:0] oldest_ext;
	logic signed [SUM_W-1:0] fill_sum;

	assign sample_ext = SUM_W'(sample);
	assign oldest_ext = SUM_W'(win_q[N-1]);
	assign fill_sum   = sample_ext * N_S;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < N; i++) begin
				win_q[i] <= '0;
			end
			sum_q   <= '0;
			ratio_q <= orwa_pkg::RATIO_RESET;
		end else begin
			if (cfg_we) begin
				ratio_q <= cfg_wdata;
			end
			if (cmd.apply) begin
				case (action)
					orwa_pkg::ACT_PUSH: begin
						for (int i = N - 1; i > 0; i--) begin
							win_q[i] <= win_q[i-1];
						end
						win_q[0] <= sample;
						sum_q    <= sum_q - oldest_ext + sample_ext;
					end
					orwa_pkg::ACT_CLEAR: begin
						for (int i = 0; i < N; i++) begin
							win_q[i] <= '0;
						end
						sum_q <= '0;
					end
					orwa_pkg::ACT_FILL: begin
						for (int i = 0; i < N; i++) begin
							win_q[i] <= sample;
						end
						sum_q <= fill_sum;
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Outlier scan. Stage 1 forms |sum - N*s|, stage 2 compares and accumulates.
	logic                    sum_zero;
	logic                    sum_neg;
	logic [CMP_W-1:0]        thr_q;
	logic signed [SW-1:0]    slot;
	logic signed [SUM_W-1:0] slot_ns;
	logic signed [D_W-1:0]   diff;
	logic [D_W-1:0]          dabs;
	logic                    v_s1;
	logic [D_W-1:0]          dabs_s1;
	logic signed [SW-1:0]    slot_s1;
	logic [CMP_W-1:0]        ten_dabs;
	logic                    outlier;
	logic signed [SUM_W-1:0] kept_sum_q;
	logic [CNT_W-1:0]        kept_q;

	assign sum_zero = (sum_q == '0);
	assign sum_neg  = sum_q[SUM_W-1];
	assign slot     = win_q[scan_idx];
	assign slot_ns  = SUM_W'(slot) * N_S;
	assign diff     = D_W'(sum_q) - D_W'(slot_ns);
	assign dabs     = diff[D_W-1] ? D_W'(-diff) : D_W'(diff);
	assign ten_dabs = CMP_W'(dabs_s1) * TEN;

	// A zero mean rejects every nonzero slot; a negative mean rejects none.
	always_comb begin
		if (sum_zero) begin
			outlier = (dabs_s1 != '0);
		end else begin
			outlier = !sum_neg && (ten_dabs > thr_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= cmd.scan;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			thr_q      <= CMP_W'(ratio_q) * CMP_W'($unsigned(sum_q));
			kept_sum_q <= '0;
			kept_q     <= '0;
		end else if (v_s1 && !outlier) begin
			kept_sum_q <= kept_sum_q + SUM_W'(slot_s1);
			kept_q     <= kept_q + 1'b1;
		end
		if (cmd.scan) begin
			dabs_s1 <= dabs;
			slot_s1 <= slot;
		end
	end

	// Restoring divider on the magnitude of the kept sum, one bit per step.
	logic             neg_q;
	logic [SUM_W-1:0] quo_q;
	logic [CNT_W-1:0] rem_q;
	logic [CNT_W:0]   rem_sh;
	logic             q_bit;
	logic [CNT_W:0]   rem_sub;

	assign rem_sh  = {rem_q, quo_q[SUM_W-1]};
	assign q_bit   = (rem_sh >= {1'b0, kept_q});
	assign rem_sub = rem_sh - {1'b0, kept_q};

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			neg_q <= kept_sum_q[SUM_W-1];
			quo_q <= kept_sum_q[SUM_W-1] ? SUM_W'(-kept_sum_q) : SUM_W'(kept_sum_q);
			rem_q <= '0;
		end else if (cmd.div_step) begin
			quo_q <= {quo_q[SUM_W-2:0], q_bit};
			rem_q <= q_bit ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
		end
	end

	// Output register.
	logic signed [SUM_W-1:0]         quo_signed;
	logic [OC_W-1:0]                 rej_count;
	logic                            out_valid_q;
	logic signed [SW-1:0]            out_average_q;
	logic [orwa_pkg::COUNT_W-1:0]    out_count_q;

	assign quo_signed = neg_q ? -$signed(quo_q) : $signed(quo_q);
	assign rej_count  = N_OC - OC_W'(kept_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			// With every slot rejected the oldest sample stands in.
			out_average_q <= (kept_q == '0) ? win_q[N-1] : quo_signed[SW-1:0];
			out_count_q   <= rej_count[orwa_pkg::COUNT_W-1:0];
		end
	end

	assign out_valid       = out_valid_q;
	assign out_average     = out_average_q;
	assign out_count       = out_count_q;
	assign status.out_free = !out_valid_q || out_ready;

	`ORWA_ASSERT_IMP(a_kept_range, clk, arst_n, cmd.div_init, kept_q <= N_CNT, "kept count beyond window depth")
	`ORWA_ASSERT_IMP(a_rem_below_div, clk, arst_n, cmd.div_step && (kept_q != '0), rem_q < kept_q, "divider remainder not below divisor")

endmodule
`default_nettype wire

// ----- rtl/outlier_rejecting_window_average_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// outlier_rejecting_window_average_core
// Robust moving average over a window of signed Q8.8 speed samples.
// ----------------------------------------------------------------------------
// Each input request pushes a sample, clears the window, fills it with one
// value or leaves it unchanged, then yields one result: the mean of the
// samples whose relative deviation from the window mean stays within
// cfg_wdata tenths, truncated toward zero, and the number of samples
// rejected. With every sample rejected the oldest sample is given. One
// request is processed at a time. After acceptance the core runs a setup
// step, the outlier scan over every slot, a pipeline flush, the divider
// load, the serial divide with one quotient bit per step, and the result
// load. The next request can be accepted in the cycle after the result is
// loaded. The result sits in an output register, so the next request is
// taken while it waits; only a finished result that finds the previous one
// still unaccepted holds the core until it is taken.
// ----------------------------------------------------------------------------
`include "outlier_rejecting_window_average_core_macros.svh"
module outlier_rejecting_window_average_core #(
	parameter int WINDOW_DEPTH = orwa_pkg::WINDOW_DEPTH_DEF,
	parameter int SAMPLE_WIDTH = orwa_pkg::SAMPLE_WIDTH_DEF,
	localparam int S_TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8,
	localparam int M_TDATA_W = ((SAMPLE_WIDTH + orwa_pkg::COUNT_W + 7) / 8) * 8
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [orwa_pkg::RATIO_W-1:0]      cfg_wdata,
	input  wire logic                              s_axis_tvalid,
	output logic                                   s_axis_tready,
	input  wire logic [S_TDATA_W-1:0]              s_axis_tdata,  // sample
	input  wire logic [orwa_pkg::ACTION_W-1:0]     s_axis_tuser,  // action
	output logic                                   m_axis_tvalid,
	input  wire logic                              m_axis_tready,
	output logic [M_TDATA_W-1:0]                   m_axis_tdata   // robust_average, outlier_count
);

	orwa_pkg::cmd_t    cmd;
	orwa_pkg::status_t status;
	logic [$clog2(WINDOW_DEPTH)-1:0] scan_idx;
	logic signed [SAMPLE_WIDTH-1:0]  out_average;
	logic [orwa_pkg::COUNT_W-1:0]    out_count;

	orwa_ctrl #(
		.WINDOW_DEPTH (WINDOW_DEPTH),
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.status        (status),
		.cmd           (cmd),
		.scan_idx      (scan_idx)
	);

	orwa_datapath #(
		.WINDOW_DEPTH (WINDOW_DEPTH),
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.scan_idx    (scan_idx),
		.status      (status),
		.action      (s_axis_tuser),
		.sample      (s_axis_tdata[SAMPLE_WIDTH-1:0]),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.out_ready   (m_axis_tready),
		.out_valid   (m_axis_tvalid),
		.out_average (out_average),
		.out_count   (out_count)
	);

	assign m_axis_tdata = M_TDATA_W'({out_count, out_average});

	`ORWA_ASSERT_NXT(a_one_request, clk, arst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "request taken while another is in progress")
	`ORWA_ASSERT_IMP(a_load_when_free, clk, arst_n, cmd.load_out, status.out_free, "result loaded over a waiting result")

endmodule
`default_nettype wire

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the outlier-rejecting window average core.
// ----------------------------------------------------------------------------
// A queue of pending requests feeds a clocked stream driver. Each accepted
// request is run through a local model of the five-slot window. The model
// gives the expected robust average and rejection count, and a clocked
// monitor compares every result against the oldest expectation. The run
// starts with directed corner cases. Then come random phases at several
// rejection ratios, under sender and receiver idling and one long receiver
// hold-off.
// ----------------------------------------------------------------------------
module tb_top;
	import orwa_pkg::*;

	localparam int DEPTH = WINDOW_DEPTH_DEF;
	localparam logic [ACTION_W-1:0] ACT_HOLD = 2'd3;
	localparam int STALL_LIMIT = 5000;
	localparam int SETTLE_CYCLES = 40;
	localparam int LONG_HOLD_CYCLES = 400;
	localparam int PHASE_ITEMS = 330;
	localparam int PHASES = 6;
	localparam logic [RATIO_W-1:0] PHASE_RATIO [PHASES] = '{4'd0, 4'd15, 4'd10, 4'd1, 4'd7, 4'd3};

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic signed [15:0] sample;
	} speed_req_t;

	typedef struct packed {
		logic signed [15:0] average;
		logic [COUNT_W-1:0] rejected;
	} avg_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [RATIO_W-1:0] cfg_wdata = '0;
	logic s_tvalid = 1'b0;
	logic [15:0] s_tdata = '0;
	logic [ACTION_W-1:0] s_tuser = '0;
	logic m_tready = 1'b0;
	logic s_axis_tready;
	logic m_axis_tvalid;
	logic [23:0] m_axis_tdata;

	speed_req_t pending_reqs[$];
	avg_result_t expected_averages[$];

	// Local copy of the window and the threshold.
	logic signed [15:0] speed_window [DEPTH] = '{default: '0};
	logic [RATIO_W-1:0] ratio_model = RATIO_RESET;

	int send_idle_pct = 28;
	int recv_idle_pct = 74;
	int long_hold_req = 0;
	int long_hold_seen = 0;
	int hold_left = 0;
	int stall_cycles = 0;
	int mismatch_count = 0;

	outlier_rejecting_window_average_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.s_axis_tvalid(s_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_tdata),
		.s_axis_tuser (s_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic avg_result_t predict_robust_average(logic [ACTION_W-1:0] act,
			logic signed [15:0] smp);
		avg_result_t r;
		longint total;
		longint kept_total;
		longint dev;
		int kept;
		int i;
		case (act)
			ACT_PUSH: begin
				for (i = DEPTH - 1; i > 0; i--)
					speed_window[i] = speed_window[i - 1];
				speed_window[0] = smp;
			end
			ACT_CLEAR: begin
				for (i = 0; i < DEPTH; i++)
					speed_window[i] = '0;
			end
			ACT_FILL: begin
				for (i = 0; i < DEPTH; i++)
					speed_window[i] = smp;
			end
			default: ;
		endcase
		total = 0;
		for (i = 0; i < DEPTH; i++)
			total += longint'(speed_window[i]);
		kept_total = 0;
		kept = 0;
		for (i = 0; i < DEPTH; i++) begin
			dev = total - longint'(DEPTH) * longint'(speed_window[i]);
			if (dev < 0)
				dev = -dev;
			// A negative mean rejects nothing; a zero mean keeps only zero slots.
			if (total < 0 || (total == 0 && dev == 0) ||
					(total > 0 && dev * 10 <= longint'(ratio_model) * total)) begin
				kept_total += longint'(speed_window[i]);
				kept++;
			end
		end
		if (kept == 0)
			r.average = speed_window[DEPTH - 1];
		else
			r.average = 16'(kept_total / kept);
		r.rejected = COUNT_W'(DEPTH - kept);
		return r;
	endfunction

	// Driver and input-side prediction.
	always @(posedge clk) begin
		speed_req_t req;
		if (cfg_we)
			ratio_model = cfg_wdata;
		if (s_tvalid && s_axis_tready)
			expected_averages.push_back(predict_robust_average(s_tuser, s_tdata));
		if (arst_n && (!s_tvalid || s_axis_tready)) begin
			if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				req = pending_reqs.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= req.sample;
				s_tuser <= req.action;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Receiver and result checker.
	always @(posedge clk) begin
		avg_result_t got;
		avg_result_t want;
		if (m_axis_tvalid && m_tready) begin
			got.average = m_axis_tdata[15:0];
			got.rejected = m_axis_tdata[16 +: COUNT_W];
			if (expected_averages.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result: average %0d rejected %0d",
						got.average, got.rejected);
			end else begin
				want = expected_averages.pop_front();
				if (got.average !== want.average || got.rejected !== want.rejected) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch: average exp %0d got %0d, rejected exp %0d got %0d",
							want.average, got.average, want.rejected, got.rejected);
				end
			end
		end
		if (long_hold_seen != long_hold_req) begin
			long_hold_seen <= long_hold_req;
			hold_left <= LONG_HOLD_CYCLES;
			m_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_axis_tready) || (m_axis_tvalid && m_tready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	task automatic queue_request(logic [ACTION_W-1:0] act, int smp);
		speed_req_t req;
		req.action = act;
		req.sample = 16'(smp);
		pending_reqs.push_back(req);
	endtask

	task automatic queue_directed();
		queue_request(ACT_HOLD, 0);
		queue_request(ACT_FILL, 32767);
		queue_request(ACT_PUSH, -32768);
		queue_request(ACT_FILL, -32768);
		queue_request(ACT_PUSH, 32767);
		queue_request(ACT_CLEAR, 0);
		// One large sample among zeros: every slot fails, oldest is given.
		queue_request(ACT_PUSH, 1000);
		queue_request(ACT_CLEAR, 0);
		queue_request(ACT_PUSH, 256);
		queue_request(ACT_PUSH, -256);
		// Window of nonzero slots summing to zero: all rejected.
		queue_request(ACT_CLEAR, 0);
		repeat (4) queue_request(ACT_PUSH, 1);
		queue_request(ACT_PUSH, -4);
		queue_request(ACT_FILL, 1280);
		queue_request(ACT_PUSH, 1300);
		queue_request(ACT_PUSH, 5000);
		queue_request(ACT_HOLD, -1);
	endtask

	// Mostly runs of pushes around a base value, so that samples land on both
	// sides of the threshold; the rest is unstructured noise.
	task automatic queue_random_phase(int n);
		int count;
		int base;
		int span;
		int run_len;
		int v;
		count = 0;
		while (count < n) begin
			if ($urandom_range(9) < 7) begin
				case ($urandom_range(2))
					0: base = int'($urandom_range(60)) - 20;
					1: base = int'($urandom_range(4000));
					default: base = int'($urandom_range(65535)) - 32768;
				endcase
				if ($urandom_range(1))
					queue_request(ACT_FILL, base);
				else
					queue_request(ACT_CLEAR, int'($urandom_range(65535)));
				span = (base < 0 ? -base : base) / 2 + 8;
				run_len = $urandom_range(10, 4);
				repeat (run_len) begin
					v = base + int'($urandom_range(2 * span)) - span;
					if (v > 32767)
						v = 32767;
					if (v < -32768)
						v = -32768;
					queue_request(ACT_PUSH, v);
				end
				count += run_len + 1;
			end else begin
				queue_request(ACT_W_CAST($urandom_range(3)), int'($urandom_range(65535)));
				count++;
			end
		end
	endtask

	function automatic logic [ACTION_W-1:0] ACT_W_CAST(int unsigned v);
		return ACTION_W'(v);
	endfunction

	task automatic wait_drained();
		while (pending_reqs.size() != 0 || s_tvalid || expected_averages.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_ratio(logic [RATIO_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int phase;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		queue_directed();
		wait_drained();
		for (phase = 0; phase < PHASES; phase++) begin
			if (phase == 2) begin
				send_idle_pct = 74;
				recv_idle_pct = 28;
			end
			if (phase == 4) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			write_ratio(PHASE_RATIO[phase]);
			// The receiver stalls while requests keep coming, filling the core.
			if (phase == 4)
				long_hold_req <= long_hold_req + 1;
			queue_random_phase(PHASE_ITEMS);
			wait_drained();
		end
		if (mismatch_count == 0 && expected_averages.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/orwa_pkg.sv
rtl/orwa_ctrl.sv
rtl/orwa_datapath.sv
rtl/outlier_rejecting_window_average_core.sv
tb/sv/tb_top.sv
